### hdl/rph_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rph_pkg
// Shared types and constants of the region-of-interest pixel histogram.
// ----------------------------------------------------------------------------
package rph_pkg;

	localparam int CFG_WIDTH       = 10;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int VALUE_WIDTH     = 8;
	localparam int CMD_WIDTH       = 2;
	localparam int OUT_COUNT_WIDTH = 32;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [CMD_WIDTH-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_WIDTH-1:0] CMD_COUNT = 2'd1;
	localparam logic [CMD_WIDTH-1:0] CMD_READ  = 2'd2;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_COL_START = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_START = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_COL_END   = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_END   = 2'd3;

	localparam logic [CFG_WIDTH-1:0] COL_START_RESET = 10'd0;
	localparam logic [CFG_WIDTH-1:0] ROW_START_RESET = 10'd0;
	localparam logic [CFG_WIDTH-1:0] COL_END_RESET   = 10'd1023;
	localparam logic [CFG_WIDTH-1:0] ROW_END_RESET   = 10'd1023;

	typedef enum logic [1:0] {
		OP_INC,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [VALUE_WIDTH-1:0] bin;
		logic                   oob;
	} item_t;

endpackage : rph_pkg
`default_nettype wire

### hdl/rph_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rph_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rph_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule : rph_ram
`default_nettype wire

### hdl/rph_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rph_front
// Region registers, input acceptance and command classification.
// ----------------------------------------------------------------------------
module rph_front #(
	parameter int BINS        = 256,
	parameter int COORD_WIDTH = 10
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [rph_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  wire logic [rph_pkg::CFG_WIDTH-1:0]        cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [rph_pkg::CMD_WIDTH-1:0]        command,
	input  wire logic [rph_pkg::VALUE_WIDTH-1:0]      pixel_value,
	input  wire logic [COORD_WIDTH-1:0]               pixel_col,
	input  wire logic [COORD_WIDTH-1:0]               pixel_row,
	input  wire logic [rph_pkg::VALUE_WIDTH-1:0]      read_bin,
	input  wire logic                                 queue_full,
	input  wire logic                                 clearing,
	output logic                                      push,
	output rph_pkg::item_t                            push_item
);

	import rph_pkg::*;

	localparam int CW = (COORD_WIDTH > CFG_WIDTH) ? COORD_WIDTH : CFG_WIDTH;

	logic [CFG_WIDTH-1:0] col_start_q;
	logic [CFG_WIDTH-1:0] row_start_q;
	logic [CFG_WIDTH-1:0] col_end_q;
	logic [CFG_WIDTH-1:0] row_end_q;
	logic                 in_region;
	logic                 keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_start_q <= COL_START_RESET;
			row_start_q <= ROW_START_RESET;
			col_end_q   <= COL_END_RESET;
			row_end_q   <= ROW_END_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COL_START: col_start_q <= cfg_data;
				REG_ROW_START: row_start_q <= cfg_data;
				REG_COL_END:   col_end_q   <= cfg_data;
				REG_ROW_END:   row_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_region = (CW'(pixel_col) >= CW'(col_start_q)) &&
		(CW'(pixel_col) <= CW'(col_end_q)) &&
		(CW'(pixel_row) >= CW'(row_start_q)) &&
		(CW'(pixel_row) <= CW'(row_end_q));

	always_comb begin
		push_item = '{op: OP_INC, bin: pixel_value, oob: 1'b0};
		keep      = 1'b0;
		case (command)
			CMD_CLEAR: begin
				push_item.op = OP_CLEAR;
				keep         = 1'b1;
			end
			CMD_COUNT: begin
				keep = in_region && (32'(pixel_value) < BINS);
			end
			CMD_READ: begin
				push_item.op  = OP_READ;
				push_item.bin = read_bin;
				push_item.oob = !(32'(read_bin) < BINS);
				keep          = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	// hold input while the queue is full or the bins are being cleared
	assign in_stall = queue_full || clearing;
	assign push     = in_valid && !in_stall && keep;

endmodule : rph_front
`default_nettype wire

### hdl/rph_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rph_queue
// Short FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module rph_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  rph_pkg::item_t      push_item,
	input  wire logic           pop,
	output rph_pkg::item_t      head,
	output logic                empty,
	output logic                full
);

	import rph_pkg::*;

	localparam int QAW = $clog2(QUEUE_DEPTH);

	item_t          entry_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign head  = entry_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == (QAW+1)'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule : rph_queue
`default_nettype wire

### hdl/rph_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rph_back
// Bin memory, read-modify-write with forwarding, clear sweep and read output.
// ----------------------------------------------------------------------------
module rph_back #(
	parameter int BINS        = 256,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  rph_pkg::item_t                            head,
	input  wire logic                                 empty,
	output logic                                      pop,
	output logic                                      clearing,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [rph_pkg::VALUE_WIDTH-1:0]           bin_number,
	output logic [rph_pkg::OUT_COUNT_WIDTH-1:0]       bin_count
);

	import rph_pkg::*;

	localparam int AW = $clog2(BINS);

	item_t                  item_s1;
	logic                   valid_s1;
	logic [AW-1:0]          addr_s1;
	logic                   clr_active_q;
	logic [AW-1:0]          clr_ptr_q;
	logic                   fwd_we_q;
	logic [AW-1:0]          fwd_addr_q;
	logic [COUNT_WIDTH-1:0] fwd_data_q;
	logic                   out_valid_q;
	logic [COUNT_WIDTH-1:0] rdata;
	logic [COUNT_WIDTH-1:0] cur;
	logic [63:0]            cur_wide;
	logic [AW-1:0]          raddr;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [COUNT_WIDTH-1:0] wdata;
	logic                   advance;
	logic                   s1_read;
	logic                   s1_clear;

	assign addr_s1  = AW'(item_s1.bin);
	assign s1_read  = valid_s1 && (item_s1.op == OP_READ);
	assign s1_clear = valid_s1 && (item_s1.op == OP_CLEAR);
	assign advance  = !(s1_read && out_valid_q && out_stall);
	assign pop      = !empty && advance && !clr_active_q && !s1_clear;
	assign raddr    = pop ? AW'(head.bin) : addr_s1;
	assign clearing = clr_active_q;

	// take the word written at the edge of the read
	assign cur      = (fwd_we_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rdata;
	assign cur_wide = 64'(cur);

	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = '0;
		if (clr_active_q) begin
			we    = 1'b1;
			waddr = clr_ptr_q;
		end else if (valid_s1 && (item_s1.op == OP_INC)) begin
			we    = 1'b1;
			wdata = (cur == {COUNT_WIDTH{1'b1}}) ? cur : cur + COUNT_WIDTH'(1);
		end
	end

	rph_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (BINS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head;
		end
		fwd_addr_q <= waddr;
		fwd_data_q <= wdata;
		if (s1_read && advance) begin
			bin_number <= item_s1.bin;
			if (item_s1.oob) begin
				bin_count <= '0;
			end else if (cur_wide > 64'hFFFF_FFFF) begin
				bin_count <= '1;
			end else begin
				bin_count <= cur_wide[OUT_COUNT_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			clr_active_q <= 1'b1;
			clr_ptr_q    <= '0;
			fwd_we_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			fwd_we_q <= we;
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (s1_clear) begin
				clr_active_q <= 1'b1;
				clr_ptr_q    <= '0;
			end else if (clr_active_q) begin
				clr_ptr_q <= clr_ptr_q + 1'b1;
				if (clr_ptr_q == AW'(BINS - 1)) begin
					clr_active_q <= 1'b0;
				end
			end
			if (s1_read && advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule : rph_back
`default_nettype wire

### hdl/roi_pixel_histogram_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// roi_pixel_histogram_unit
// Histogram of 8-bit pixels inside a rectangular region of interest.
// Throughput: one count or read word per cycle while the output is not stalled
// and no clear is in progress, set by the bin RAM read-modify-write loop with
// forwarding; a clear holds the back end until its sweep has zeroed every bin.
// Reset: region registers return to the full frame; a clearing pass zeroes
// the bin RAM while input is stalled.
// ----------------------------------------------------------------------------
module roi_pixel_histogram_unit #(
	parameter int BINS        = 256,
	parameter int COUNT_WIDTH = 32,
	parameter int COORD_WIDTH = 10
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [rph_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  wire logic [rph_pkg::CFG_WIDTH-1:0]        cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [rph_pkg::CMD_WIDTH-1:0]        command,
	input  wire logic [rph_pkg::VALUE_WIDTH-1:0]      pixel_value,
	input  wire logic [COORD_WIDTH-1:0]               pixel_col,
	input  wire logic [COORD_WIDTH-1:0]               pixel_row,
	input  wire logic [rph_pkg::VALUE_WIDTH-1:0]      read_bin,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [rph_pkg::VALUE_WIDTH-1:0]           bin_number,
	output logic [rph_pkg::OUT_COUNT_WIDTH-1:0]       bin_count
);

	import rph_pkg::*;

	item_t push_item;
	item_t head;
	logic  push;
	logic  pop;
	logic  empty;
	logic  full;
	logic  clearing;

	rph_front #(
		.BINS        (BINS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.pixel_value (pixel_value),
		.pixel_col   (pixel_col),
		.pixel_row   (pixel_row),
		.read_bin    (read_bin),
		.queue_full  (full),
		.clearing    (clearing),
		.push        (push),
		.push_item   (push_item)
	);

	rph_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	rph_back #(
		.BINS        (BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.clearing   (clearing),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.bin_number (bin_number),
		.bin_count  (bin_count)
	);

endmodule : roi_pixel_histogram_unit
`default_nettype wire
